// File: rtl/fct_pkg.sv
// ----------------------------------------------------------------------------
// fct_pkg
// Shared types and constants of the fragment coverage tracker.
// ----------------------------------------------------------------------------
package fct_pkg;

    localparam int LEN_W   = 17;
    localparam int END_W   = 17;
    localparam int CHUNK_W = 17;
    localparam int COUNT_W = 4;
    localparam int OUT_W   = 8;

    localparam logic [CHUNK_W-1:0] CHUNK_RESET = 17'h10000;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        PH_SEEK,
        PH_GATHER,
        PH_COPY
    } phase_t;

endpackage

// File: rtl/fragment_coverage_tracker_top.sv
// ----------------------------------------------------------------------------
// fragment_coverage_tracker_top
// Keeps a sorted list of disjoint covered byte ranges of one chunk, merges
// each fragment into it and reports acceptance, completion and list length.
// ----------------------------------------------------------------------------
// A request walks the stored intervals in turn, with one extra step when the
// merged interval lands before the end of the list, before the next request
// can be taken; zero-length and out-of-range requests skip the walk. A
// waiting result adds its stall on top.
// The walk is paced by the interval memory, which is read one entry per
// cycle through its single read port while the new list is written into the
// other bank. Results sit in an output register, so a request is taken while
// the previous result still waits.
module fragment_coverage_tracker_top
    import fct_pkg::*;
#(
    parameter int MAX_PARTS   = 8,
    parameter int OFFSET_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CHUNK_W-1:0]   cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // frag_offset, frag_length, zero fill
    input  logic [((OFFSET_BITS+LEN_W+7)/8)*8-1:0] s_tdata,
    // start_new
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status, complete, interval_count, zero fill
    output logic [OUT_W-1:0]     m_tdata
);

    localparam int IDX_W      = $clog2(MAX_PARTS);
    localparam int CNT_W      = $clog2(MAX_PARTS + 1);
    localparam int BANK_DEPTH = 1 << IDX_W;
    localparam int CMP_W      = (OFFSET_BITS > END_W) ? OFFSET_BITS : END_W;
    localparam int SUM_W      = CMP_W + 1;

    // interval memory, two banks
    logic [OFFSET_BITS-1:0] mem_start [2*BANK_DEPTH];
    logic [END_W-1:0]       mem_end   [2*BANK_DEPTH];

    state_t                 st_reg, st_next;
    phase_t                 ph_reg, ph_next;
    logic [CNT_W-1:0]       p_reg, p_next;
    logic [CNT_W-1:0]       w_reg, w_next;
    logic [CNT_W-1:0]       used_reg, used_next;
    logic                   done_reg, done_next;
    logic                   bank_reg, bank_next;
    stat_t                  stat_reg, stat_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [END_W-1:0]       fend_reg, fend_next;
    logic [OFFSET_BITS-1:0] ns_reg, ns_next;
    logic [END_W-1:0]       ne_reg, ne_next;
    logic [OFFSET_BITS-1:0] head_s_reg, head_s_next;
    logic [END_W-1:0]       head_e_reg, head_e_next;
    logic [OFFSET_BITS-1:0] cap_s_reg, cap_s_next;
    logic [END_W-1:0]       cap_e_reg, cap_e_next;
    logic [CHUNK_W-1:0]     chunk_reg;
    logic [OFFSET_BITS-1:0] rd_s_reg;
    logic [END_W-1:0]       rd_e_reg;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]       m_tdata_reg, m_tdata_next;

    logic                   in_acc;
    logic [OFFSET_BITS-1:0] in_off;
    logic [LEN_W-1:0]       in_len;
    logic [SUM_W-1:0]       in_sum;
    logic                   in_beyond;

    logic                   at_end, is_before, is_touch, is_full;
    logic                   scan_fin, scan_rej, scan_commit;
    logic                   wr_en, wr_merged, p_inc, do_gather, to_copy;
    logic [OFFSET_BITS-1:0] wr_s;
    logic [END_W-1:0]       wr_e;
    logic [IDX_W:0]         wr_addr, rd_addr;
    logic                   out_free, done_eval;

    assign s_tready = (st_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign in_acc    = s_tvalid && s_tready;
    assign in_off    = s_tdata[OFFSET_BITS-1:0];
    assign in_len    = s_tdata[OFFSET_BITS +: LEN_W];
    assign in_sum    = SUM_W'(in_off) + SUM_W'(in_len);
    assign in_beyond = in_sum > SUM_W'(chunk_reg);

    assign out_free  = !m_tvalid_reg || m_tready;
    assign done_eval = done_reg || ((used_reg != '0) && (head_s_reg == '0) &&
                                    (head_e_reg >= chunk_reg));

    // scan decode
    always_comb begin
        at_end    = (p_reg == used_reg);
        is_before = (ph_reg == PH_SEEK) && (CMP_W'(rd_e_reg) < CMP_W'(off_reg));
        is_touch  = CMP_W'(rd_s_reg) <= CMP_W'(fend_reg);
        is_full   = (ph_reg != PH_GATHER) && (used_reg >= CNT_W'(MAX_PARTS));
        scan_fin  = 1'b0;
        scan_rej  = 1'b0;
        wr_en     = 1'b0;
        wr_merged = 1'b0;
        p_inc     = 1'b0;
        do_gather = 1'b0;
        to_copy   = 1'b0;
        if (st_reg == ST_SCAN) begin
            priority if (at_end) begin
                scan_fin = 1'b1;
                if (ph_reg != PH_COPY) begin
                    if (is_full) begin
                        scan_rej = 1'b1;
                    end else begin
                        wr_en     = 1'b1;
                        wr_merged = 1'b1;
                    end
                end
            end else if (is_before) begin
                wr_en = 1'b1;
                p_inc = 1'b1;
            end else if (ph_reg != PH_COPY && is_touch) begin
                do_gather = 1'b1;
                p_inc     = 1'b1;
            end else if (ph_reg != PH_COPY) begin
                if (is_full) begin
                    scan_fin = 1'b1;
                    scan_rej = 1'b1;
                end else begin
                    wr_en     = 1'b1;
                    wr_merged = 1'b1;
                    to_copy   = 1'b1;
                end
            end else begin
                wr_en = 1'b1;
                p_inc = 1'b1;
            end
        end
        scan_commit = scan_fin && !scan_rej;
        wr_s    = wr_merged ? ns_reg : rd_s_reg;
        wr_e    = wr_merged ? ne_reg : rd_e_reg;
        wr_addr = {~bank_reg, w_reg[IDX_W-1:0]};
    end

    // next state
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (in_len == '0 || in_beyond) begin
                        st_next = ST_FINISH;
                    end else begin
                        st_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_fin) begin
                    st_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        ph_next       = ph_reg;
        p_next        = p_reg;
        w_next        = w_reg;
        used_next     = used_reg;
        done_next     = done_reg;
        bank_next     = bank_reg;
        stat_next     = stat_reg;
        off_next      = off_reg;
        fend_next     = fend_reg;
        ns_next       = ns_reg;
        ne_next       = ne_reg;
        head_s_next   = head_s_reg;
        head_e_next   = head_e_reg;
        cap_s_next    = cap_s_reg;
        cap_e_next    = cap_e_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        if (in_acc) begin
            off_next  = in_off;
            fend_next = in_sum[END_W-1:0];
            ns_next   = in_off;
            ne_next   = in_sum[END_W-1:0];
            ph_next   = PH_SEEK;
            p_next    = '0;
            w_next    = '0;
            if (s_tuser) begin
                used_next = '0;
                done_next = 1'b0;
            end
            if (in_len == '0) begin
                stat_next = STAT_OK;
            end else if (in_beyond) begin
                stat_next = STAT_RANGE;
            end else begin
                stat_next = STAT_OK;
            end
        end

        if (p_inc) begin
            p_next = p_reg + 1'b1;
        end
        if (do_gather) begin
            ph_next = PH_GATHER;
            ns_next = (rd_s_reg < ns_reg) ? rd_s_reg : ns_reg;
            ne_next = (rd_e_reg > ne_reg) ? rd_e_reg : ne_reg;
        end
        if (to_copy) begin
            ph_next = PH_COPY;
        end
        if (wr_en) begin
            w_next = w_reg + 1'b1;
            if (w_reg == '0) begin
                cap_s_next = wr_s;
                cap_e_next = wr_e;
            end
        end
        if (scan_rej) begin
            stat_next = STAT_FULL;
        end
        if (scan_commit) begin
            bank_next = ~bank_reg;
            used_next = w_next;
            if (wr_en && w_reg == '0) begin
                head_s_next = wr_s;
                head_e_next = wr_e;
            end else begin
                head_s_next = cap_s_reg;
                head_e_next = cap_e_reg;
            end
        end

        if (st_reg == ST_FINISH && out_free) begin
            done_next     = done_eval;
            m_tvalid_next = 1'b1;
            m_tdata_next  = {1'b0, COUNT_W'(used_reg), done_eval, stat_reg};
        end

        rd_addr = {bank_reg, p_next[IDX_W-1:0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_IDLE;
            ph_reg       <= PH_SEEK;
            p_reg        <= '0;
            w_reg        <= '0;
            used_reg     <= '0;
            done_reg     <= 1'b0;
            bank_reg     <= 1'b0;
            stat_reg     <= STAT_OK;
            chunk_reg    <= CHUNK_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            st_reg       <= st_next;
            ph_reg       <= ph_next;
            p_reg        <= p_next;
            w_reg        <= w_next;
            used_reg     <= used_next;
            done_reg     <= done_next;
            bank_reg     <= bank_next;
            stat_reg     <= stat_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                chunk_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        off_reg     <= off_next;
        fend_reg    <= fend_next;
        ns_reg      <= ns_next;
        ne_reg      <= ne_next;
        head_s_reg  <= head_s_next;
        head_e_reg  <= head_e_next;
        cap_s_reg   <= cap_s_next;
        cap_e_reg   <= cap_e_next;
        m_tdata_reg <= m_tdata_next;
    end

    // interval memory ports
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_start[wr_addr] <= wr_s;
            mem_end[wr_addr]   <= wr_e;
        end
        rd_s_reg <= mem_start[rd_addr];
        rd_e_reg <= mem_end[rd_addr];
    end

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CNT_W'(MAX_PARTS))
        else $error("interval count above table size");

    a_wr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (w_reg < CNT_W'(MAX_PARTS)))
        else $error("interval write beyond table");

    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (done_reg && !(in_acc && s_tuser)) |=> done_reg)
        else $error("completion dropped without new chunk");

    a_reject_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_rej |=> ($stable(used_reg) && $stable(bank_reg)))
        else $error("rejected request changed the list");

    a_finish_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_fin |=> (st_reg == ST_FINISH))
        else $error("scan end did not reach result stage");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Fragment coverage tracker testbench. A queue of fragment requests feeds a
// clocked driver; a clocked monitor checks every response against an
// in-bench interval-list model. Chunk size changes only while the tracker
// is idle. Directed corner cases run first, then random fragment sequences,
// with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module tb_top;
    import fct_pkg::*;

    localparam int MAX_PARTS      = 8;
    localparam int OFFSET_BITS    = 16;
    localparam int TDATA_W        = ((OFFSET_BITS + LEN_W + 7) / 8) * 8;
    localparam int RANDOM_ITEMS   = 1350;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        logic                   start_new;
        logic [OFFSET_BITS-1:0] off;
        logic [LEN_W-1:0]       len;
    } frag_req_t;

    typedef struct packed {
        stat_t              stat;
        logic               complete;
        logic [COUNT_W-1:0] count;
    } tracker_resp_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [CHUNK_W-1:0] cfg_wr_data = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;
    logic               s_tuser = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OUT_W-1:0]   m_tdata;

    fragment_coverage_tracker_top #(
        .MAX_PARTS   (MAX_PARTS),
        .OFFSET_BITS (OFFSET_BITS)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // interval list model
    logic [OFFSET_BITS-1:0] iv_lo [MAX_PARTS];
    logic [END_W-1:0]       iv_hi [MAX_PARTS];
    int                     iv_used = 0;
    logic                   covered = 1'b0;
    logic [CHUNK_W-1:0]     chunk_len = CHUNK_RESET;

    frag_req_t     frag_q [$];
    tracker_resp_t tracker_resp_q [$];
    frag_req_t     drv_req;
    int            gap_left = 0;
    int            stall_left = 0;
    int            quiet_cycles = 0;
    int            mismatches = 0;
    int            issued = 0;
    bit            calm = 1'b0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic int min2(int a, int b);
        return (a < b) ? a : b;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic tracker_resp_t track_fragment(frag_req_t rq);
        tracker_resp_t          r;
        int                     lo, hi, n;
        logic [17:0]            fend;
        logic [OFFSET_BITS-1:0] ns;
        logic [END_W-1:0]       ne;
        logic [OFFSET_BITS-1:0] ts [MAX_PARTS];
        logic [END_W-1:0]       te [MAX_PARTS];
        r.stat = STAT_OK;
        if (rq.start_new) begin
            iv_used = 0;
            covered = 1'b0;
        end
        fend = 18'(rq.off) + 18'(rq.len);
        if (rq.len != 0) begin
            if (fend > 18'(chunk_len)) begin
                r.stat = STAT_RANGE;
            end else begin
                lo = 0;
                while (lo < iv_used && iv_hi[lo] < rq.off) lo++;
                hi = lo;
                ns = rq.off;
                ne = fend[END_W-1:0];
                while (hi < iv_used && 18'(iv_lo[hi]) <= fend) begin
                    if (iv_lo[hi] < ns) ns = iv_lo[hi];
                    if (iv_hi[hi] > ne) ne = iv_hi[hi];
                    hi++;
                end
                if (hi == lo && iv_used >= MAX_PARTS) begin
                    r.stat = STAT_FULL;
                end else begin
                    n = 0;
                    for (int i = 0; i < lo; i++) begin
                        ts[n] = iv_lo[i];
                        te[n] = iv_hi[i];
                        n++;
                    end
                    ts[n] = ns;
                    te[n] = ne;
                    n++;
                    for (int i = hi; i < iv_used && n < MAX_PARTS; i++) begin
                        ts[n] = iv_lo[i];
                        te[n] = iv_hi[i];
                        n++;
                    end
                    for (int i = 0; i < n; i++) begin
                        iv_lo[i] = ts[i];
                        iv_hi[i] = te[i];
                    end
                    iv_used = n;
                end
            end
        end
        if (iv_used > 0 && iv_lo[0] == 0 && iv_hi[0] >= chunk_len) covered = 1'b1;
        r.complete = covered;
        r.count = iv_used[COUNT_W-1:0];
        return r;
    endfunction

    task automatic check_field(string fld, int want, int got);
        if (want != got) begin
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, fld, want, got);
            mismatches++;
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready)
                tracker_resp_q.insert(tracker_resp_q.size(), track_fragment(drv_req));
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (frag_q.size() != 0) begin
                    drv_req = frag_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {{(TDATA_W - OFFSET_BITS - LEN_W){1'b0}}, drv_req.len,
                                drv_req.off};
                    s_tuser <= drv_req.start_new;
                    gap_left = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        tracker_resp_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (tracker_resp_q.size() == 0) begin
                    $display("%0t unexpected response: expected none, actual %h", $time,
                             m_tdata);
                    mismatches++;
                end else begin
                    want = tracker_resp_q.pop_front();
                    check_field("status", want.stat, m_tdata[1:0]);
                    check_field("complete", want.complete, m_tdata[2]);
                    check_field("interval_count", want.count, m_tdata[6:3]);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 5) == 0) stall_left = pick_gap();
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL fragment_coverage_tracker_top");
            $finish;
        end
    end

    task automatic push_frag(bit sn, int off, int len);
        frag_req_t rq;
        rq.start_new = sn;
        rq.off = off[OFFSET_BITS-1:0];
        rq.len = len[LEN_W-1:0];
        frag_q.insert(frag_q.size(), rq);
        issued++;
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        while (frag_q.size() != 0 || s_tvalid || tracker_resp_q.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_chunk(int value);
        wait_idle();
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value[CHUNK_W-1:0];
        chunk_len = value[CHUNK_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic gen_sequence(int cs);
        int steps, cursor, r, off, len, room, span;
        bit tiled, sn;
        steps = $urandom_range(3, 24);
        tiled = $urandom_range(0, 1);
        cursor = 0;
        for (int k = 0; k < steps; k++) begin
            sn = (k == 0) || ($urandom_range(0, 49) == 0);
            r = $urandom_range(0, 99);
            if (cs == 0 || r >= 92) begin
                off = $urandom_range(0, 65535);
                len = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 65536)
                                                  : $urandom_range(0, 16);
            end else if (r >= 86) begin
                off = $urandom_range(0, 65535);
                len = 0;
            end else if (r >= 78) begin
                off = $urandom_range(0, min2(cs, 65535));
                len = min2(cs - off + $urandom_range(1, 16), 65536);
            end else begin
                if (!tiled || cursor >= min2(cs, 65536))
                    cursor = $urandom_range(0, min2(cs - 1, 65535));
                off = cursor;
                room = min2(cs - off, 65536);
                if (tiled)
                    span = cs / 6 + 1;
                else
                    span = ($urandom_range(0, 3) == 0) ? cs : cs / 8 + 1;
                len = $urandom_range(1, min2(room, span));
                cursor = off + len + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
            end
            push_frag(sn, off, len);
        end
    endtask

    initial begin
        int cs, r, nseq;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // zero length, chunk end, full cover, already covered, out of range
        push_frag(1, 0, 0);
        push_frag(0, 65535, 0);
        push_frag(0, 65535, 1);
        push_frag(0, 0, 65536);
        push_frag(0, 100, 10);
        push_frag(1, 1, 65536);
        push_frag(0, 65535, 65536);
        // fill the table, overflow, fuse, refill, touch two
        for (int i = 0; i < MAX_PARTS; i++) push_frag(i == 0, i * 10, 5);
        push_frag(0, 80, 5);
        push_frag(0, 5, 5);
        push_frag(0, 80, 5);
        push_frag(0, 75, 5);
        // completion only after the chunk size is lowered
        write_chunk(100);
        push_frag(1, 0, 80);
        write_chunk(50);
        push_frag(0, 0, 0);
        // zero chunk size
        write_chunk(0);
        push_frag(1, 0, 1);
        push_frag(0, 0, 0);

        while (issued < RANDOM_ITEMS) begin
            r = $urandom_range(0, 9);
            case (r)
                0: begin
                    case ($urandom_range(0, 4))
                        0: cs = 0;
                        1: cs = 1;
                        2: cs = 2;
                        3: cs = 131071;
                        default: cs = 65536;
                    endcase
                end
                1, 2, 3, 4, 5: cs = $urandom_range(1, 64);
                6, 7: cs = $urandom_range(65, 2048);
                8: cs = $urandom_range(2049, 65536);
                default: cs = 65536;
            endcase
            write_chunk(cs);
            calm = ($urandom_range(0, 3) == 0);
            nseq = $urandom_range(2, 6);
            repeat (nseq) gen_sequence(cs);
        end

        wait_idle();
        if (mismatches == 0 && tracker_resp_q.size() == 0) begin
            $display("PASS fragment_coverage_tracker_top");
        end else begin
            $display("FAIL fragment_coverage_tracker_top");
        end
        $finish;
    end

endmodule
